### design/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg - shared types and constants for the DH kinematics chain
// CORDIC table, fixed-point constants and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dhfk_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS    = 5;
    // CORDIC datapath width: Q2.30 plus headroom for growth
    localparam int CW           = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] C_QUARTER   = 34'sd1073741824;
    localparam logic signed [CW-1:0] C_HALFTURN  = 34'sd2147483648;

    localparam logic signed [31:0] ROT_IDENT [9] = '{
        32'sd1073741824, 32'sd0, 32'sd0,
        32'sd0, 32'sd1073741824, 32'sd0,
        32'sd0, 32'sd0, 32'sd1073741824
    };

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_COS_T  = 7'b0000010,
        ST_COS_A  = 7'b0000100,
        ST_LINK   = 7'b0001000,
        ST_PROD   = 7'b0010000,
        ST_COMMIT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_cprep;

    // arctangent per step, 2^32 phase units per turn
    function automatic logic signed [CW-1:0] atan_entry(input logic [STEP_BITS-1:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/dhfk_if.sv
// ----------------------------------------------------------------------------
// dhfk_if - joint and pose channels of the DH kinematics chain
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhfk_joint_if #(
    parameter int ANGLE_BITS = 16,
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] joint_angle;
    logic signed [ANGLE_BITS-1:0] link_twist;
    logic signed [VALUE_BITS-1:0] link_length;
    logic signed [VALUE_BITS-1:0] link_offset;
    logic                         last_joint;

    modport source (output valid, joint_angle, link_twist, link_length, link_offset,
                    last_joint, input ready);
    modport sink   (input valid, joint_angle, link_twist, link_length, link_offset,
                    last_joint, output ready);
endinterface

interface dhfk_pose_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [31:0]           rot_00, rot_01, rot_02;
    logic signed [31:0]           rot_10, rot_11, rot_12;
    logic signed [31:0]           rot_20, rot_21, rot_22;
    logic signed [VALUE_BITS-1:0] trans_x, trans_y, trans_z;

    modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                    rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
    modport sink   (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                    rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

`default_nettype wire

### design/dh_forward_kinematics_chain.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain - DH forward kinematics, fixed point
// Accumulates a 3x4 pose over joint words and emits it on the last joint.
// ----------------------------------------------------------------------------
// The block takes no new joint word until it is done with the current one:
// one CORDIC stage runs 30 steps for the joint angle and 30 for the twist,
// then a single 34 x 25 multiplier, used in two halves per product with a
// rounding pass, forms the 6 link-matrix products and the 36 pose products.
// A pose word is offered after the last joint and is held until taken; the
// accumulated pose returns to identity as the last joint is committed.
`default_nettype none

module dh_forward_kinematics_chain #(
    parameter int ANGLE_BITS = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dhfk_joint_if.sink   i_joint,
    dhfk_pose_if.source  o_pose
);

    localparam int CW  = dhfk_pkg::CW;
    localparam int QW  = (VALUE_BITS + 2 > CW) ? VALUE_BITS + 2 : CW;
    localparam int HW  = QW - 24;
    localparam int MW  = (HW > 25) ? HW : 25;
    localparam int FW  = CW + QW;
    localparam int TW  = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 4;
    localparam int SW  = TW + 2;

    localparam logic signed [FW-1:0] C_RND   = FW'(1) << 29;
    localparam logic signed [SW-1:0] C_R_MAX = SW'(32'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] C_R_MIN = SW'(32'sh8000_0000);
    localparam logic signed [SW-1:0] C_T_MAX = SW'({1'b0, {(VALUE_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] C_T_MIN = -C_T_MAX - SW'(1);

    dhfk_pkg::t_state r_state;

    logic [dhfk_pkg::STEP_BITS-1:0] r_step;
    logic [1:0]                     r_ph;
    logic [2:0]                     r_idx;
    logic [3:0]                     r_e;
    logic [1:0]                     r_k;

    logic signed [ANGLE_BITS-1:0] r_twist;
    logic signed [VALUE_BITS-1:0] r_len, r_off;
    logic                         r_last;

    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic                 r_flip;
    logic signed [CW-1:0] r_ct, r_st, r_ca, r_sa;
    logic signed [CW-1:0] r_rl1, r_rl2, r_rl4, r_rl5;
    logic signed [QW-1:0] r_tl0, r_tl1;

    logic signed [31:0]           r_pose_rot [9];
    logic signed [VALUE_BITS-1:0] r_pose_tr  [3];
    logic signed [31:0]           r_nrot     [9];
    logic signed [VALUE_BITS-1:0] r_ntr      [3];

    logic signed [CW+MW-1:0] r_prod;
    logic signed [FW-1:0]    r_full;
    logic signed [SW-1:0]    r_sum;

    function automatic dhfk_pkg::t_cprep cprep(input logic [ANGLE_BITS-1:0] ang);
        logic [31:0]          ph;
        logic signed [CW-1:0] z;
        dhfk_pkg::t_cprep     r;
        ph     = 32'(ang) << (32 - ANGLE_BITS);
        z      = CW'(signed'(ph));
        r.flip = (z > dhfk_pkg::C_QUARTER) || (z < -dhfk_pkg::C_QUARTER);
        if (!r.flip) begin
            r.z = z;
        end else if (z > 0) begin
            r.z = z - dhfk_pkg::C_HALFTURN;
        end else begin
            r.z = z + dhfk_pkg::C_HALFTURN;
        end
        return r;
    endfunction

    // ---- CORDIC step ----
    logic signed [CW-1:0] n_cx, n_cy, n_cz, c_res_x, c_res_y;
    logic signed [CW-1:0] c_dx, c_dy, c_at;
    dhfk_pkg::t_cprep     c_prep_in, c_prep_tw;
    logic                 c_end;

    always_comb begin
        c_dx = r_cy >>> r_step;
        c_dy = r_cx >>> r_step;
        c_at = dhfk_pkg::atan_entry(r_step);
        if (!r_cz[CW-1]) begin
            n_cx = r_cx - c_dx;
            n_cy = r_cy + c_dy;
            n_cz = r_cz - c_at;
        end else begin
            n_cx = r_cx + c_dx;
            n_cy = r_cy - c_dy;
            n_cz = r_cz + c_at;
        end
        c_res_x   = r_flip ? -n_cx : n_cx;
        c_res_y   = r_flip ? -n_cy : n_cy;
        c_prep_in = cprep(i_joint.joint_angle);
        c_prep_tw = cprep(r_twist);
        c_end     = (r_step == dhfk_pkg::STEP_BITS'(dhfk_pkg::CORDIC_STEPS - 1));
    end

    // ---- multiplier operand selection ----
    logic [1:0]           m_i, m_j;
    logic [3:0]           m_pidx, m_ridx;
    logic signed [CW-1:0] m_p;
    logic signed [QW-1:0] m_q;
    logic signed [MW-1:0] m_m;
    logic signed [QW-1:0] rl_v [9];
    logic signed [QW-1:0] tl_v [3];

    always_comb begin
        m_i    = r_e[3:2];
        m_j    = r_e[1:0];
        m_pidx = 4'(m_i) * 4'd3 + 4'(r_k);
        m_ridx = 4'(r_k) * 4'd3 + 4'(m_j);
        rl_v[0] = QW'(r_ct);
        rl_v[1] = QW'(r_rl1);
        rl_v[2] = QW'(r_rl2);
        rl_v[3] = QW'(r_st);
        rl_v[4] = QW'(r_rl4);
        rl_v[5] = QW'(r_rl5);
        rl_v[6] = '0;
        rl_v[7] = QW'(r_sa);
        rl_v[8] = QW'(r_ca);
        tl_v[0] = r_tl0;
        tl_v[1] = r_tl1;
        tl_v[2] = QW'(r_off);
        m_p = '0;
        m_q = '0;
        if (r_state == dhfk_pkg::ST_LINK) begin
            case (r_idx)
                3'd0: begin m_p = r_st; m_q = QW'(r_ca); end
                3'd1: begin m_p = r_st; m_q = QW'(r_sa); end
                3'd2: begin m_p = r_ct; m_q = QW'(r_ca); end
                3'd3: begin m_p = r_ct; m_q = QW'(r_sa); end
                3'd4: begin m_p = r_ct; m_q = QW'(r_len); end
                3'd5: begin m_p = r_st; m_q = QW'(r_len); end
                default: begin m_p = '0; m_q = '0; end
            endcase
        end else begin
            m_p = CW'(r_pose_rot[m_pidx]);
            m_q = (m_j == 2'd3) ? tl_v[r_k] : rl_v[m_ridx];
        end
        // low half unsigned, high half signed
        if (r_ph == 2'd0) begin
            m_m = MW'(signed'({1'b0, m_q[23:0]}));
        end else begin
            m_m = MW'(signed'(m_q[QW-1:24]));
        end
    end

    // ---- rounding and accumulation ----
    logic signed [TW-1:0] a_term;
    logic signed [SW-1:0] a_in, a_sum, a_sat_r, a_sat_t;

    always_comb begin
        a_term = signed'(r_full[30 +: TW]);
        if (r_k != 2'd0) begin
            a_in = r_sum;
        end else if (m_j == 2'd3) begin
            a_in = SW'(r_pose_tr[m_i]);
        end else begin
            a_in = '0;
        end
        a_sum   = a_in + SW'(a_term);
        a_sat_r = (a_sum > C_R_MAX) ? C_R_MAX : ((a_sum < C_R_MIN) ? C_R_MIN : a_sum);
        a_sat_t = (a_sum > C_T_MAX) ? C_T_MAX : ((a_sum < C_T_MIN) ? C_T_MIN : a_sum);
    end

    // ---- sequencer and datapath ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhfk_pkg::ST_IDLE;
            r_step  <= '0;
            r_ph    <= '0;
            r_idx   <= '0;
            r_e     <= '0;
            r_k     <= '0;
            r_last  <= 1'b0;
            for (int n = 0; n < 9; n++) begin
                r_pose_rot[n] <= dhfk_pkg::ROT_IDENT[n];
            end
            for (int n = 0; n < 3; n++) begin
                r_pose_tr[n] <= '0;
            end
        end else begin
            case (r_state)
                dhfk_pkg::ST_IDLE: begin
                    if (i_joint.valid) begin
                        r_twist <= i_joint.link_twist;
                        r_len   <= i_joint.link_length;
                        r_off   <= i_joint.link_offset;
                        r_last  <= i_joint.last_joint;
                        r_cx    <= dhfk_pkg::CORDIC_GAIN;
                        r_cy    <= '0;
                        r_cz    <= c_prep_in.z;
                        r_flip  <= c_prep_in.flip;
                        r_step  <= '0;
                        r_state <= dhfk_pkg::ST_COS_T;
                    end
                end
                dhfk_pkg::ST_COS_T, dhfk_pkg::ST_COS_A: begin
                    r_cx   <= n_cx;
                    r_cy   <= n_cy;
                    r_cz   <= n_cz;
                    r_step <= r_step + 1'b1;
                    if (c_end) begin
                        r_step <= '0;
                        if (r_state == dhfk_pkg::ST_COS_T) begin
                            r_ct    <= c_res_x;
                            r_st    <= c_res_y;
                            r_cx    <= dhfk_pkg::CORDIC_GAIN;
                            r_cy    <= '0;
                            r_cz    <= c_prep_tw.z;
                            r_flip  <= c_prep_tw.flip;
                            r_state <= dhfk_pkg::ST_COS_A;
                        end else begin
                            r_ca    <= c_res_x;
                            r_sa    <= c_res_y;
                            r_idx   <= '0;
                            r_ph    <= '0;
                            r_state <= dhfk_pkg::ST_LINK;
                        end
                    end
                end
                dhfk_pkg::ST_LINK, dhfk_pkg::ST_PROD: begin
                    r_ph <= r_ph + 1'b1;
                    case (r_ph)
                        2'd0: r_prod <= m_p * m_m;
                        2'd1: begin
                            r_full <= FW'(r_prod);
                            r_prod <= m_p * m_m;
                        end
                        2'd2: r_full <= r_full + (FW'(r_prod) <<< 24) + C_RND;
                        default: begin
                            if (r_state == dhfk_pkg::ST_LINK) begin
                                case (r_idx)
                                    3'd0: r_rl1 <= -CW'(a_term);
                                    3'd1: r_rl2 <= CW'(a_term);
                                    3'd2: r_rl4 <= CW'(a_term);
                                    3'd3: r_rl5 <= -CW'(a_term);
                                    3'd4: r_tl0 <= QW'(a_term);
                                    default: r_tl1 <= QW'(a_term);
                                endcase
                                r_idx <= r_idx + 1'b1;
                                if (r_idx == 3'd5) begin
                                    r_e     <= '0;
                                    r_k     <= '0;
                                    r_state <= dhfk_pkg::ST_PROD;
                                end
                            end else begin
                                r_sum <= a_sum;
                                r_k   <= r_k + 1'b1;
                                if (r_k == 2'd2) begin
                                    r_k <= '0;
                                    if (m_j == 2'd3) begin
                                        r_ntr[m_i] <= a_sat_t[VALUE_BITS-1:0];
                                    end else begin
                                        r_nrot[4'(m_i) * 4'd3 + 4'(m_j)] <= a_sat_r[31:0];
                                    end
                                    r_e <= r_e + 1'b1;
                                    if (r_e == 4'd11) begin
                                        r_state <= dhfk_pkg::ST_COMMIT;
                                    end
                                end
                            end
                        end
                    endcase
                end
                dhfk_pkg::ST_COMMIT: begin
                    for (int n = 0; n < 9; n++) begin
                        r_pose_rot[n] <= r_last ? dhfk_pkg::ROT_IDENT[n] : r_nrot[n];
                    end
                    for (int n = 0; n < 3; n++) begin
                        r_pose_tr[n] <= r_last ? '0 : r_ntr[n];
                    end
                    r_state <= r_last ? dhfk_pkg::ST_DONE : dhfk_pkg::ST_IDLE;
                end
                dhfk_pkg::ST_DONE: begin
                    if (o_pose.ready) begin
                        r_state <= dhfk_pkg::ST_IDLE;
                    end
                end
                default: r_state <= dhfk_pkg::ST_IDLE;
            endcase
        end
    end

    assign i_joint.ready = (r_state == dhfk_pkg::ST_IDLE);
    assign o_pose.valid  = (r_state == dhfk_pkg::ST_DONE);
    assign o_pose.rot_00 = r_nrot[0];
    assign o_pose.rot_01 = r_nrot[1];
    assign o_pose.rot_02 = r_nrot[2];
    assign o_pose.rot_10 = r_nrot[3];
    assign o_pose.rot_11 = r_nrot[4];
    assign o_pose.rot_12 = r_nrot[5];
    assign o_pose.rot_20 = r_nrot[6];
    assign o_pose.rot_21 = r_nrot[7];
    assign o_pose.rot_22 = r_nrot[8];
    assign o_pose.trans_x = r_ntr[0];
    assign o_pose.trans_y = r_ntr[1];
    assign o_pose.trans_z = r_ntr[2];

    // ---- checks ----
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_joint.ready && o_pose.valid))
        else $error("joint taken while pose word pending");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_joint.valid && i_joint.ready) |=> (r_state == dhfk_pkg::ST_COS_T))
        else $error("accepted joint did not start CORDIC");

    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pose.valid) |-> r_last)
        else $error("pose emitted for a joint not marked last");

    a_pose_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dhfk_pkg::ST_COMMIT && r_last) |=>
            (r_pose_rot[0] == dhfk_pkg::ROT_IDENT[0] && r_pose_tr[0] == '0))
        else $error("pose not returned to identity after last joint");

endmodule

`default_nettype wire

### dv/dh_forward_kinematics_chain_test.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_test - self-checking bench for the DH chain
// Drives joint words through random idle/stall phases, predicts each pose
// with a bit-exact CORDIC and fixed-point product model, compares per field.
// ----------------------------------------------------------------------------
`default_nettype none

module dh_forward_kinematics_chain_test;

    localparam int AB = 16;
    localparam int VB = 32;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct packed {
        logic signed [AB-1:0] theta;
        logic signed [AB-1:0] alpha;
        logic signed [VB-1:0] len;
        logic signed [VB-1:0] offs;
        logic                 last;
    } joint_t;

    typedef struct packed {
        logic signed [31:0] r00, r01, r02;
        logic signed [VB-1:0] tx;
        logic signed [31:0] r10, r11, r12;
        logic signed [VB-1:0] ty;
        logic signed [31:0] r20, r21, r22;
        logic signed [VB-1:0] tz;
    } pose_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dhfk_joint_if #(.ANGLE_BITS(AB), .VALUE_BITS(VB)) joint_ch ();
    dhfk_pose_if #(.VALUE_BITS(VB)) pose_ch ();

    dh_forward_kinematics_chain #(.ANGLE_BITS(AB), .VALUE_BITS(VB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_joint (joint_ch.sink),
        .o_pose  (pose_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    joint_t joint_q[$];
    pose_t  pose_q[$];
    longint pose_rot[9];
    longint pose_tr[3];
    int     fails = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off = 0;
    longint cycles = 0;

    // floor((p*q + 2^29) / 2^30); split q so the product fits 64 bits
    function automatic longint mul_q30(longint p, longint q);
        longint qh, ql, a, b, ah, al;
        qh = q >>> 24;
        ql = q - qh * 64'sd16777216;
        a  = p * qh;
        b  = p * ql + (ONE_Q30 >>> 1);
        ah = a >>> 6;
        al = a - ah * 64;
        return ah + ((al * 64'sd16777216 + b) >>> 30);
    endfunction

    function automatic longint clamp_bits(longint v, int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1};
        return tab[i];
    endfunction

    task automatic cordic_sincos(input logic [AB-1:0] ang, output longint c,
                                 output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'({ang, {(32-AB){1'b0}}});
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > ONE_Q30 || z < -ONE_Q30) begin
            z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic void pose_to_identity();
        for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? ONE_Q30 : 0;
        for (int i = 0; i < 3; i++) pose_tr[i] = 0;
    endfunction

    task automatic chain_joint(input joint_t j);
        longint ct, st, ca, sa, acc;
        longint rl[9], tl[3], nr[9], nt[3];
        pose_t p;
        cordic_sincos(j.theta, ct, st);
        cordic_sincos(j.alpha, ca, sa);
        rl = '{ct, -mul_q30(st, ca), mul_q30(st, sa),
               st, mul_q30(ct, ca), -mul_q30(ct, sa),
               0, sa, ca};
        tl = '{mul_q30(ct, longint'(j.len)), mul_q30(st, longint'(j.len)),
               longint'(j.offs)};
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += mul_q30(pose_rot[i*3+k], rl[k*3+c]);
                nr[i*3+c] = clamp_bits(acc, 32);
            end
            acc = pose_tr[i];
            for (int k = 0; k < 3; k++) acc += mul_q30(pose_rot[i*3+k], tl[k]);
            nt[i] = clamp_bits(acc, VB);
        end
        pose_rot = nr;
        pose_tr = nt;
        if (j.last) begin
            p.r00 = 32'(nr[0]); p.r01 = 32'(nr[1]); p.r02 = 32'(nr[2]); p.tx = VB'(nt[0]);
            p.r10 = 32'(nr[3]); p.r11 = 32'(nr[4]); p.r12 = 32'(nr[5]); p.ty = VB'(nt[1]);
            p.r20 = 32'(nr[6]); p.r21 = 32'(nr[7]); p.r22 = 32'(nr[8]); p.tz = VB'(nt[2]);
            pose_q = {pose_q, p};
            pose_to_identity();
        end
    endtask

    function automatic joint_t make_joint(int ta, int tw, int l, int o, bit last);
        joint_t j;
        j.theta = AB'(ta); j.alpha = AB'(tw); j.len = VB'(l); j.offs = VB'(o);
        j.last = last;
        return j;
    endfunction

    task automatic queue_joint(input joint_t j);
        joint_q = {joint_q, j};
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff);
        endcase
    endfunction

    function automatic logic [AB-1:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return AB'(16'h4000 * $urandom_range(0, 3));
            default: return AB'($urandom());
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            joint_ch.valid <= 1'b0;
        end else begin
            if (joint_ch.valid && joint_ch.ready) begin
                chain_joint(joint_q.pop_front());
            end
            if (!(joint_ch.valid && !joint_ch.ready)) begin
                if (joint_q.size() > 0 && !(joint_ch.valid && joint_ch.ready
                        && joint_q.size() == 0)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    joint_ch.valid       <= 1'b1;
                    joint_ch.joint_angle <= joint_q[0].theta;
                    joint_ch.link_twist  <= joint_q[0].alpha;
                    joint_ch.link_length <= joint_q[0].len;
                    joint_ch.link_offset <= joint_q[0].offs;
                    joint_ch.last_joint  <= joint_q[0].last;
                end else begin
                    joint_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        pose_t e;
        cycles++;
        if (!i_rst_n) begin
            pose_ch.ready <= 1'b0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                if (pose_q.size() == 0) begin
                    $error("pose word with no expectation pending");
                    fails++;
                end else begin
                    e = pose_q.pop_front();
                    check_field("rot_00", e.r00, pose_ch.rot_00);
                    check_field("rot_01", e.r01, pose_ch.rot_01);
                    check_field("rot_02", e.r02, pose_ch.rot_02);
                    check_field("trans_x", e.tx, pose_ch.trans_x);
                    check_field("rot_10", e.r10, pose_ch.rot_10);
                    check_field("rot_11", e.r11, pose_ch.rot_11);
                    check_field("rot_12", e.r12, pose_ch.rot_12);
                    check_field("trans_y", e.ty, pose_ch.trans_y);
                    check_field("rot_20", e.r20, pose_ch.rot_20);
                    check_field("rot_21", e.r21, pose_ch.rot_21);
                    check_field("rot_22", e.r22, pose_ch.rot_22);
                    check_field("trans_z", e.tz, pose_ch.trans_z);
                end
            end
            pose_ch.ready <= (hold_off == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // generous limit: 900 words, stalls and gaps several times over
    always @(posedge i_clk) begin
        if (cycles > 2000000) begin
            $display("dh_forward_kinematics_chain_test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (joint_q.size() > 0 || joint_ch.valid || pose_q.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int chain_len;
        joint_ch.valid = 1'b0;
        joint_ch.joint_angle = '0;
        joint_ch.link_twist = '0;
        joint_ch.link_length = '0;
        joint_ch.link_offset = '0;
        joint_ch.last_joint = 1'b0;
        pose_ch.ready = 1'b0;
        pose_to_identity();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, quarter turns, single-joint chains
        queue_joint(make_joint(0, 0, 0, 0, 1));
        queue_joint(make_joint(16'h4000, 0, 32'h00010000, 0, 1));
        queue_joint(make_joint(16'h8000, 16'h8000, 32'h7fffffff, 32'h80000000, 1));
        queue_joint(make_joint(16'hc000, 16'h4000, 32'h80000000, 32'h7fffffff, 1));
        queue_joint(make_joint(16'h7fff, 16'h7fff, 32'hffffffff, 32'h00000001, 1));
        queue_joint(make_joint(16'h8001, 16'hc000, 32'h12345678, 32'hedcba987, 0));
        queue_joint(make_joint(16'h2000, 16'h1555, 32'h00030000, 32'h00020000, 0));
        queue_joint(make_joint(16'hffff, 16'h0001, 32'h55555555, 32'haaaaaaaa, 1));
        // saturation: long chains of huge links
        for (int i = 0; i < 8; i++)
            queue_joint(make_joint(0, 0, 32'h7fffffff, 32'h7fffffff, i == 7));
        for (int i = 0; i < 6; i++)
            queue_joint(make_joint(16'h8000, 0, 32'h7fffffff, 32'h80000000, i == 5));
        wait_drained();

        // random phases: no gaps, sender gaps, receiver stalls, both, then pressure
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) hold_off = 3000;
            for (int n = 0; n < 175; ) begin
                chain_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                        : $urandom_range(1, 6);
                for (int k = 0; k < chain_len; k++, n++)
                    queue_joint(make_joint(rand_angle(), rand_angle(), rand_value(),
                                           rand_value(), k == chain_len - 1));
            end
            wait_drained();
        end
        repeat (300) @(posedge i_clk);
        if (fails == 0 && pose_q.size() == 0)
            $display("dh_forward_kinematics_chain_test passed");
        else
            $display("dh_forward_kinematics_chain_test failed");
        $finish;
    end

endmodule

`default_nettype wire
